FILE: sv/peu_pkg.sv
// Shared types, constants and color tables for the particle Euler update block.
`timescale 1ns / 1ps

package peu_pkg;

    // Default parameter values for the top level.
    localparam int POSITION_BITS_DEF   = 32;
    localparam int FRAME_FRAC_BITS_DEF = 16;

    // Fixed field widths.
    localparam int KIND_W  = 3;
    localparam int RAMP_W  = 16;
    localparam int RAMP_FRAC_W = 12;
    localparam int RAMP_IDX_W  = RAMP_W - RAMP_FRAC_W;
    localparam int RATE_W  = 4;
    localparam int PAL_W   = 8;

    // Gravity register and the per-item gravity step.
    localparam int GRAV_W      = 12;
    localparam logic [GRAV_W-1:0] GRAVITY_DEFAULT = 12'd800;
    localparam int GRAV_STEP_W = 16;
    // The gravity product is cut down to this many bits before the divide by five.
    localparam int GRAV_T_W     = 18;
    localparam int DIV5_RECIP_W = 16;
    localparam logic [DIV5_RECIP_W-1:0] DIV5_RECIP = 16'd52429;

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_GRAVITY = 1'b0;

    // Ramp rates and table limits.
    localparam logic [RATE_W-1:0] RATE_FIRE     = 4'd5;
    localparam logic [RATE_W-1:0] RATE_EXPLODE  = 4'd10;
    localparam logic [RATE_W-1:0] RATE_EXPLODE2 = 4'd15;
    localparam logic [RAMP_IDX_W-1:0] LIMIT_FIRE = 4'd6;
    localparam logic [RAMP_IDX_W-1:0] LIMIT_FULL = 4'd8;

    typedef enum logic [KIND_W-1:0] {
        KIND_STATIC   = 3'd0,
        KIND_FIRE     = 3'd1,
        KIND_EXPLODE  = 3'd2,
        KIND_EXPLODE2 = 3'd3,
        KIND_BLOB     = 3'd4,
        KIND_BLOB2    = 3'd5,
        KIND_GRAV     = 3'd6,
        KIND_SLOWGRAV = 3'd7
    } t_kind;

    // Per-axis velocity operation. At most one of the scaled terms is active.
    typedef struct packed {
        logic add_fast;   // v + v*ft*4
        logic sub_fast;   // v - v*ft*4
        logic sub_slow;   // v - v*ft
        logic add_grav;   // z lift
        logic sub_grav;   // z pull down
    } t_axis_ctl;

    function automatic logic [PAL_W-1:0] fire_colour(input logic [2:0] idx);
        logic [PAL_W-1:0] c;
        case (idx)
            3'd0:    c = 8'h6d;
            3'd1:    c = 8'h6b;
            3'd2:    c = 8'h06;
            3'd3:    c = 8'h05;
            3'd4:    c = 8'h04;
            3'd5:    c = 8'h03;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [PAL_W-1:0] explode_colour(input logic [2:0] idx);
        logic [PAL_W-1:0] c;
        case (idx)
            3'd0:    c = 8'h6f;
            3'd1:    c = 8'h6d;
            3'd2:    c = 8'h6b;
            3'd3:    c = 8'h69;
            3'd4:    c = 8'h67;
            3'd5:    c = 8'h65;
            3'd6:    c = 8'h63;
            default: c = 8'h61;
        endcase
        return c;
    endfunction

    function automatic logic [PAL_W-1:0] explode2_colour(input logic [2:0] idx);
        logic [PAL_W-1:0] c;
        case (idx)
            3'd0:    c = 8'h6f;
            3'd1:    c = 8'h6e;
            3'd2:    c = 8'h6d;
            3'd3:    c = 8'h6c;
            3'd4:    c = 8'h6b;
            3'd5:    c = 8'h6a;
            3'd6:    c = 8'h68;
            default: c = 8'h66;
        endcase
        return c;
    endfunction

endpackage

FILE: sv/peu_axis.sv
// One axis of the update: position step, velocity step and saturation.
`timescale 1ns / 1ps

module peu_axis #(
    parameter int POSITION_BITS   = peu_pkg::POSITION_BITS_DEF,
    parameter int FRAME_FRAC_BITS = peu_pkg::FRAME_FRAC_BITS_DEF
) (
    input  logic signed [POSITION_BITS-1:0]   i_pos,
    input  logic signed [POSITION_BITS-1:0]   i_vel,
    input  logic        [FRAME_FRAC_BITS-1:0] i_ft,
    input  peu_pkg::t_axis_ctl                i_ctl,
    input  logic        [peu_pkg::GRAV_STEP_W-1:0] i_grav,
    output logic signed [POSITION_BITS-1:0]   o_pos,
    output logic signed [POSITION_BITS-1:0]   o_vel
);
    import peu_pkg::*;

    localparam int PROD_W = POSITION_BITS + FRAME_FRAC_BITS + 1;
    localparam int SUM_W  = POSITION_BITS + 18;
    localparam int SLOW_W = PROD_W - FRAME_FRAC_BITS;
    localparam int FAST_W = PROD_W - FRAME_FRAC_BITS + 2;

    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  slow_x;
    logic signed [SUM_W-1:0]  fast_x;
    logic signed [SUM_W-1:0]  pos_x;
    logic signed [SUM_W-1:0]  vel_x;
    logic signed [SUM_W-1:0]  grav_x;
    logic signed [SUM_W-1:0]  scaled_term;
    logic signed [SUM_W-1:0]  grav_term;
    logic signed [SUM_W-1:0]  pos_sum;
    logic signed [SUM_W-1:0]  vel_sum;

    function automatic logic [POSITION_BITS-1:0] sat_f(input logic [SUM_W-1:0] v);
        logic [SUM_W-POSITION_BITS:0] top;
        logic [POSITION_BITS-1:0]     r;
        top = v[SUM_W-1:POSITION_BITS-1];
        if ((&top) || !(|top)) begin
            r = v[POSITION_BITS-1:0];
        end else if (v[SUM_W-1]) begin
            r = {1'b1, {(POSITION_BITS-1){1'b0}}};
        end else begin
            r = {1'b0, {(POSITION_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    // Exact product of velocity and frame time; the arithmetic shifts below floor it.
    assign prod = i_vel * $signed({1'b0, i_ft});

    assign slow_x = $signed({{(SUM_W-SLOW_W){prod[PROD_W-1]}},
                             prod[PROD_W-1:FRAME_FRAC_BITS]});
    assign fast_x = $signed({{(SUM_W-FAST_W){prod[PROD_W-1]}},
                             prod[PROD_W-1:FRAME_FRAC_BITS-2]});
    assign pos_x  = $signed({{(SUM_W-POSITION_BITS){i_pos[POSITION_BITS-1]}}, i_pos});
    assign vel_x  = $signed({{(SUM_W-POSITION_BITS){i_vel[POSITION_BITS-1]}}, i_vel});
    assign grav_x = $signed({{(SUM_W-GRAV_STEP_W){1'b0}}, i_grav});

    always_comb begin
        if (i_ctl.add_fast) begin
            scaled_term = fast_x;
        end else if (i_ctl.sub_fast) begin
            scaled_term = -fast_x;
        end else if (i_ctl.sub_slow) begin
            scaled_term = -slow_x;
        end else begin
            scaled_term = '0;
        end

        if (i_ctl.add_grav) begin
            grav_term = grav_x;
        end else if (i_ctl.sub_grav) begin
            grav_term = -grav_x;
        end else begin
            grav_term = '0;
        end
    end

    assign pos_sum = pos_x + slow_x;
    assign vel_sum = vel_x + scaled_term + grav_term;

    assign o_pos = $signed(sat_f(pos_sum));
    assign o_vel = $signed(sat_f(vel_sum));

endmodule

FILE: sv/particle_euler_update.sv
// Top level of the particle Euler update: handshake, register stages, gravity and ramp logic.
`timescale 1ns / 1ps

// Usage
// The input channel (i_valid / o_stall) carries one particle per beat: frame time,
// kind, position, velocity and color ramp. The output channel (o_valid / i_stall)
// returns one updated particle per beat, always exactly one result per input beat.
// An input beat is taken at a rising edge with i_valid high and o_stall low.
// The block is a two-register pipeline: an input register that also holds the
// product of frame time and gravity, and a result register after the single pass
// of per-axis multiplies, the divide-by-five reciprocal multiply and the adders.
// An accepted beat moves from the input register into the result register, and
// o_valid rises when it lands there. Throughput is one beat per cycle, because
// both registers advance together whenever the receiver is not stalling.
// When the receiver holds i_stall, the result register keeps its beat, the input
// register still fills once, and o_stall rises only when both stages are full.
// The gravity register sits on an APB-style port at byte address 0; zero there
// means a gravity of 800. It must be written only while no beats are in flight.
// Synchronous reset empties both stages and sets gravity back to 800.
module particle_euler_update #(
    parameter int POSITION_BITS   = peu_pkg::POSITION_BITS_DEF,
    parameter int FRAME_FRAC_BITS = peu_pkg::FRAME_FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [peu_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [peu_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [peu_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready,
    // Input channel
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [FRAME_FRAC_BITS-1:0]             i_frame_time,
    input  logic [peu_pkg::KIND_W-1:0]             i_particle_kind,
    input  logic signed [POSITION_BITS-1:0]        i_pos_x,
    input  logic signed [POSITION_BITS-1:0]        i_pos_y,
    input  logic signed [POSITION_BITS-1:0]        i_pos_z,
    input  logic signed [POSITION_BITS-1:0]        i_vel_x,
    input  logic signed [POSITION_BITS-1:0]        i_vel_y,
    input  logic signed [POSITION_BITS-1:0]        i_vel_z,
    input  logic [peu_pkg::RAMP_W-1:0]             i_ramp_in,
    // Output channel
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [POSITION_BITS-1:0]        o_new_pos_x,
    output logic signed [POSITION_BITS-1:0]        o_new_pos_y,
    output logic signed [POSITION_BITS-1:0]        o_new_pos_z,
    output logic signed [POSITION_BITS-1:0]        o_new_vel_x,
    output logic signed [POSITION_BITS-1:0]        o_new_vel_y,
    output logic signed [POSITION_BITS-1:0]        o_new_vel_z,
    output logic [peu_pkg::RAMP_W-1:0]             o_ramp_out,
    output logic [peu_pkg::PAL_W-1:0]              o_palette_index,
    output logic                                   o_colour_written,
    output logic                                   o_expired
);
    import peu_pkg::*;

    localparam int FTG_W       = FRAME_FRAC_BITS + GRAV_W;
    localparam int DIV_PROD_W  = GRAV_T_W + DIV5_RECIP_W;
    localparam int RAMP_PROD_W = FRAME_FRAC_BITS + RATE_W;
    localparam int RAMP_WIDE_W = RAMP_PROD_W + RAMP_FRAC_W;

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [GRAV_W-1:0]    r_gravity;
    logic [GRAV_W-1:0]    gravity_eff;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_GRAVITY);
    assign prdata  = (reg_idx == REG_GRAVITY) ?
                     {{(APB_DATA_W-GRAV_W){1'b0}}, r_gravity} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= GRAVITY_DEFAULT;
        end else if (cfg_wr) begin
            r_gravity <= pwdata[GRAV_W-1:0];
        end
    end

    // A zero in the register stands for the default gravity.
    assign gravity_eff = (r_gravity == '0) ? GRAVITY_DEFAULT : r_gravity;

    // ---------------------------------------------------------------
    // Handshake and stage control
    // ---------------------------------------------------------------
    logic r_s1_vld;
    logic r_o_vld;
    logic n_s1_vld;
    logic n_o_vld;
    logic s2_ready;
    logic s1_ready;
    logic s1_move;
    logic in_acc;

    assign s2_ready = !r_o_vld || !i_stall;
    assign s1_move  = r_s1_vld && s2_ready;
    assign s1_ready = !r_s1_vld || s2_ready;
    assign in_acc   = i_valid && s1_ready;
    assign o_stall  = !s1_ready;
    assign o_valid  = r_o_vld;

    always_comb begin
        n_s1_vld = r_s1_vld;
        if (in_acc) begin
            n_s1_vld = 1'b1;
        end else if (s1_move) begin
            n_s1_vld = 1'b0;
        end
        n_o_vld = s2_ready ? r_s1_vld : r_o_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
            r_o_vld  <= n_o_vld;
        end
    end

    // ---------------------------------------------------------------
    // Input register. The frame time times gravity is formed on the way in,
    // so the pass that follows holds only one multiply per path.
    // ---------------------------------------------------------------
    logic [FRAME_FRAC_BITS-1:0]      r_s1_ft;
    logic [FTG_W-1:0]                r_s1_ftg;
    logic [FTG_W-1:0]                n_s1_ftg;
    t_kind                           r_s1_kind;
    logic signed [POSITION_BITS-1:0] r_s1_pos [3];
    logic signed [POSITION_BITS-1:0] r_s1_vel [3];
    logic [RAMP_W-1:0]               r_s1_ramp;

    assign n_s1_ftg = FTG_W'(i_frame_time) * FTG_W'(gravity_eff);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_ft     <= i_frame_time;
            r_s1_ftg    <= n_s1_ftg;
            r_s1_kind   <= t_kind'(i_particle_kind);
            r_s1_pos[0] <= i_pos_x;
            r_s1_pos[1] <= i_pos_y;
            r_s1_pos[2] <= i_pos_z;
            r_s1_vel[0] <= i_vel_x;
            r_s1_vel[1] <= i_vel_y;
            r_s1_vel[2] <= i_vel_z;
            r_s1_ramp   <= i_ramp_in;
        end
    end

    // ---------------------------------------------------------------
    // Gravity step: floor(ft * g * 64 / (5 * 2^F)). The low F-6 bits are
    // dropped first, then the remaining 18-bit value is divided by five with
    // a reciprocal multiply that is exact over that range.
    // ---------------------------------------------------------------
    logic [GRAV_T_W-1:0]    grav_t;
    logic [DIV_PROD_W-1:0]  grav_div;
    logic [GRAV_STEP_W-1:0] grav_step;

    assign grav_t    = r_s1_ftg[FTG_W-1 -: GRAV_T_W];
    assign grav_div  = DIV_PROD_W'(grav_t) * DIV_PROD_W'(DIV5_RECIP);
    assign grav_step = grav_div[DIV_PROD_W-1 -: GRAV_STEP_W];

    // ---------------------------------------------------------------
    // Kind decode into per-axis operations and ramp settings
    // ---------------------------------------------------------------
    t_axis_ctl              ctl_xy;
    t_axis_ctl              ctl_z;
    logic [RATE_W-1:0]      ramp_rate;
    logic [RAMP_IDX_W-1:0]  ramp_limit;
    logic                   has_ramp;

    always_comb begin
        ctl_xy     = '0;
        ctl_z      = '0;
        ramp_rate  = '0;
        ramp_limit = LIMIT_FULL;
        has_ramp   = 1'b0;
        case (r_s1_kind)
            KIND_FIRE: begin
                ctl_z.add_grav = 1'b1;
                ramp_rate      = RATE_FIRE;
                ramp_limit     = LIMIT_FIRE;
                has_ramp       = 1'b1;
            end
            KIND_EXPLODE: begin
                ctl_xy.add_fast = 1'b1;
                ctl_z.add_fast  = 1'b1;
                ctl_z.sub_grav  = 1'b1;
                ramp_rate       = RATE_EXPLODE;
                has_ramp        = 1'b1;
            end
            KIND_EXPLODE2: begin
                ctl_xy.sub_slow = 1'b1;
                ctl_z.sub_slow  = 1'b1;
                ctl_z.sub_grav  = 1'b1;
                ramp_rate       = RATE_EXPLODE2;
                has_ramp        = 1'b1;
            end
            KIND_BLOB: begin
                ctl_xy.add_fast = 1'b1;
                ctl_z.add_fast  = 1'b1;
                ctl_z.sub_grav  = 1'b1;
            end
            KIND_BLOB2: begin
                ctl_xy.sub_fast = 1'b1;
                ctl_z.sub_grav  = 1'b1;
            end
            KIND_GRAV, KIND_SLOWGRAV: begin
                ctl_z.sub_grav = 1'b1;
            end
            default: begin
                ctl_xy = '0;
                ctl_z  = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Color ramp: advance by ft * rate, saturate, then look up the table or expire.
    // ---------------------------------------------------------------
    logic [RAMP_PROD_W-1:0] ramp_prod;
    logic [RAMP_WIDE_W-1:0] ramp_wide;
    logic [RAMP_W-1:0]      ramp_inc;
    logic [RAMP_W:0]        ramp_sum;
    logic [RAMP_W-1:0]      ramp_sat;
    logic [RAMP_IDX_W-1:0]  ramp_idx;
    logic [RAMP_W-1:0]      n_ramp;
    logic [PAL_W-1:0]       n_pal;
    logic                   n_cw;
    logic                   n_exp;

    assign ramp_prod = RAMP_PROD_W'(r_s1_ft) * RAMP_PROD_W'(ramp_rate);
    assign ramp_wide = {ramp_prod, {RAMP_FRAC_W{1'b0}}} >> FRAME_FRAC_BITS;
    assign ramp_inc  = ramp_wide[RAMP_W-1:0];
    assign ramp_sum  = {1'b0, r_s1_ramp} + {1'b0, ramp_inc};
    assign ramp_sat  = ramp_sum[RAMP_W] ? {RAMP_W{1'b1}} : ramp_sum[RAMP_W-1:0];
    assign ramp_idx  = ramp_sat[RAMP_W-1 -: RAMP_IDX_W];

    always_comb begin
        n_ramp = r_s1_ramp;
        n_pal  = '0;
        n_cw   = 1'b0;
        n_exp  = 1'b0;
        if (has_ramp) begin
            n_ramp = ramp_sat;
            if (ramp_idx >= ramp_limit) begin
                n_exp = 1'b1;
            end else begin
                n_cw = 1'b1;
                case (r_s1_kind)
                    KIND_FIRE:     n_pal = fire_colour(ramp_idx[2:0]);
                    KIND_EXPLODE:  n_pal = explode_colour(ramp_idx[2:0]);
                    KIND_EXPLODE2: n_pal = explode2_colour(ramp_idx[2:0]);
                    default:       n_pal = '0;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Per-axis datapath
    // ---------------------------------------------------------------
    logic signed [POSITION_BITS-1:0] n_pos [3];
    logic signed [POSITION_BITS-1:0] n_vel [3];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        peu_axis #(
            .POSITION_BITS   (POSITION_BITS),
            .FRAME_FRAC_BITS (FRAME_FRAC_BITS)
        ) u_axis (
            .i_pos  (r_s1_pos[a]),
            .i_vel  (r_s1_vel[a]),
            .i_ft   (r_s1_ft),
            .i_ctl  ((a == 2) ? ctl_z : ctl_xy),
            .i_grav (grav_step),
            .o_pos  (n_pos[a]),
            .o_vel  (n_vel[a])
        );
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic signed [POSITION_BITS-1:0] r_o_pos [3];
    logic signed [POSITION_BITS-1:0] r_o_vel [3];
    logic [RAMP_W-1:0]               r_o_ramp;
    logic [PAL_W-1:0]                r_o_pal;
    logic                            r_o_cw;
    logic                            r_o_exp;

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_o_pos[0] <= n_pos[0];
            r_o_pos[1] <= n_pos[1];
            r_o_pos[2] <= n_pos[2];
            r_o_vel[0] <= n_vel[0];
            r_o_vel[1] <= n_vel[1];
            r_o_vel[2] <= n_vel[2];
            r_o_ramp   <= n_ramp;
            r_o_pal    <= n_pal;
            r_o_cw     <= n_cw;
            r_o_exp    <= n_exp;
        end
    end

    assign o_new_pos_x      = r_o_pos[0];
    assign o_new_pos_y      = r_o_pos[1];
    assign o_new_pos_z      = r_o_pos[2];
    assign o_new_vel_x      = r_o_vel[0];
    assign o_new_vel_y      = r_o_vel[1];
    assign o_new_vel_z      = r_o_vel[2];
    assign o_ramp_out       = r_o_ramp;
    assign o_palette_index  = r_o_pal;
    assign o_colour_written = r_o_cw;
    assign o_expired        = r_o_exp;

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the particle Euler update block.
`timescale 1ns / 1ps

module tb_top;
    import peu_pkg::*;

    // One particle as it enters the block, one updated particle as it leaves.
    typedef struct packed {
        logic [15:0]        ft;
        t_kind              kind;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [15:0]        ramp;
    } t_particle;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [15:0]        ramp;
        logic [7:0]         pal;
        logic               wr;
        logic               dead;
    } t_update;

    // A row of the directed table. When typed is set, the expected update is
    // the one written in the row, otherwise it comes from the predictor.
    typedef struct packed {
        t_particle p;
        logic      typed;
        t_update   r;
    } t_row;

    localparam logic [11:0] GRAVITY_AT_RESET = 12'd800;
    localparam logic [APB_ADDR_W-1:0] GRAVITY_ADDR = {REG_GRAVITY, 2'b00};
    localparam int RANDOM_PER_PHASE = 240;
    localparam int DRAIN_LIMIT = 5000;

    // Ramp speeds and how far each color table reaches.
    localparam longint FIRE_SPEED     = 5;
    localparam longint EXPLODE_SPEED  = 10;
    localparam longint EXPLODE2_SPEED = 15;
    localparam longint FIRE_ENTRIES   = 6;
    localparam longint FULL_ENTRIES   = 8;

    localparam logic [7:0] FIRE_SHADES [0:7] =
        '{8'h6d, 8'h6b, 8'h06, 8'h05, 8'h04, 8'h03, 8'h00, 8'h00};
    localparam logic [7:0] EXPLODE_SHADES [0:7] =
        '{8'h6f, 8'h6d, 8'h6b, 8'h69, 8'h67, 8'h65, 8'h63, 8'h61};
    localparam logic [7:0] EXPLODE2_SHADES [0:7] =
        '{8'h6f, 8'h6e, 8'h6d, 8'h6c, 8'h6b, 8'h6a, 8'h68, 8'h66};

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic               i_valid;
    logic               o_stall;
    logic [15:0]        i_frame_time;
    logic [KIND_W-1:0]  i_particle_kind;
    logic signed [31:0] i_pos_x;
    logic signed [31:0] i_pos_y;
    logic signed [31:0] i_pos_z;
    logic signed [31:0] i_vel_x;
    logic signed [31:0] i_vel_y;
    logic signed [31:0] i_vel_z;
    logic [15:0]        i_ramp_in;

    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_new_pos_x;
    logic signed [31:0] o_new_pos_y;
    logic signed [31:0] o_new_pos_z;
    logic signed [31:0] o_new_vel_x;
    logic signed [31:0] o_new_vel_y;
    logic signed [31:0] o_new_vel_z;
    logic [15:0]        o_ramp_out;
    logic [7:0]         o_palette_index;
    logic               o_colour_written;
    logic               o_expired;

    // Expected updates in beat order, the gravity value the block should hold,
    // and the count of every failure seen so far.
    t_update     pending_updates[$];
    t_row        directed_rows[$];
    logic [11:0] gravity_setting = GRAVITY_AT_RESET;
    int          mismatch_count = 0;
    int          burst_left = 0;

    particle_euler_update uut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #1_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // Exact product of a velocity and the frame time, floored after the shift.
    function automatic longint ft_product(input longint v, input logic [15:0] ft,
                                          input int shift);
        return (v * longint'(ft)) >>> shift;
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'h7fff_ffff;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic t_update update_particle(input t_particle p);
        longint  posv [3];
        longint  velv [3];
        longint  nv [3];
        longint  gstep;
        longint  speed;
        longint  entries;
        longint  ramp_sum;
        longint  slot;
        longint  g;
        t_update u;

        posv[0] = longint'(p.px);
        posv[1] = longint'(p.py);
        posv[2] = longint'(p.pz);
        velv[0] = longint'(p.vx);
        velv[1] = longint'(p.vy);
        velv[2] = longint'(p.vz);
        nv = velv;
        speed = 0;
        entries = FULL_ENTRIES;
        u = '0;

        // Gravity step in Q23.8: ft * g / 20 with ft in Q0.16; zero means default.
        g = (gravity_setting == 12'd0) ? longint'(GRAVITY_AT_RESET)
                                       : longint'(gravity_setting);
        gstep = (longint'(p.ft) * g * 256) / (20 * 65536);

        case (p.kind)
            KIND_FIRE: begin
                speed = FIRE_SPEED;
                entries = FIRE_ENTRIES;
                nv[2] = velv[2] + gstep;
            end
            KIND_EXPLODE, KIND_BLOB: begin
                if (p.kind == KIND_EXPLODE) speed = EXPLODE_SPEED;
                for (int i = 0; i < 3; i++) nv[i] = velv[i] + ft_product(velv[i], p.ft, 14);
                nv[2] -= gstep;
            end
            KIND_EXPLODE2: begin
                speed = EXPLODE2_SPEED;
                for (int i = 0; i < 3; i++) nv[i] = velv[i] - ft_product(velv[i], p.ft, 16);
                nv[2] -= gstep;
            end
            KIND_BLOB2: begin
                for (int i = 0; i < 2; i++) nv[i] = velv[i] - ft_product(velv[i], p.ft, 14);
                nv[2] -= gstep;
            end
            KIND_GRAV, KIND_SLOWGRAV: begin
                nv[2] -= gstep;
            end
            default: begin
            end
        endcase

        // Color ramp: advance, saturate, then look up the table or expire.
        ramp_sum = longint'(p.ramp);
        if (speed != 0) begin
            ramp_sum += ((longint'(p.ft) * speed) << 12) >> 16;
            if (ramp_sum > 64'sd65535) ramp_sum = 64'sd65535;
            slot = ramp_sum >> 12;
            if (slot >= entries) begin
                u.dead = 1'b1;
            end else begin
                u.wr = 1'b1;
                case (p.kind)
                    KIND_FIRE:    u.pal = FIRE_SHADES[slot];
                    KIND_EXPLODE: u.pal = EXPLODE_SHADES[slot];
                    default:      u.pal = EXPLODE2_SHADES[slot];
                endcase
            end
        end
        u.ramp = ramp_sum[15:0];

        // Positions move by the incoming velocity, not the updated one.
        u.px = clamp32(posv[0] + ft_product(velv[0], p.ft, 16));
        u.py = clamp32(posv[1] + ft_product(velv[1], p.ft, 16));
        u.pz = clamp32(posv[2] + ft_product(velv[2], p.ft, 16));
        u.vx = clamp32(nv[0]);
        u.vy = clamp32(nv[1]);
        u.vz = clamp32(nv[2]);
        return u;
    endfunction

    // ---------------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Every beat taken on the output is matched against the oldest expectation.
    // Outputs are read at the edge itself, before the block updates them.
    always @(posedge i_clk) begin
        t_update want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_updates.size() == 0) begin
                $error("result beat arrived with no particle outstanding");
                mismatch_count++;
            end else begin
                want = pending_updates.pop_front();
                check_field("new_pos_x", want.px, o_new_pos_x);
                check_field("new_pos_y", want.py, o_new_pos_y);
                check_field("new_pos_z", want.pz, o_new_pos_z);
                check_field("new_vel_x", want.vx, o_new_vel_x);
                check_field("new_vel_y", want.vy, o_new_vel_y);
                check_field("new_vel_z", want.vz, o_new_vel_z);
                check_field("ramp_out", 32'(want.ramp), 32'(o_ramp_out));
                check_field("palette_index", 32'(want.pal), 32'(o_palette_index));
                check_field("colour_written", 32'(want.wr), 32'(o_colour_written));
                check_field("expired", 32'(want.dead), 32'(o_expired));
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: stalls on its own pattern. Segments alternate between random
    // stall densities (including none at all) and, every so often, a long
    // hold-off that lets the sender fill both pipeline stages so the block
    // has to push back on its input.
    // ---------------------------------------------------------------------
    initial begin
        int segment;
        int len;
        int density;
        segment = 0;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (segment % 10 == 2) begin
                i_stall <= 1'b1;
                len = $urandom_range(40, 90);
                repeat (len) @(posedge i_clk);
            end else begin
                case ($urandom_range(0, 3))
                    0:       density = 0;
                    1:       density = 20;
                    2:       density = 50;
                    default: density = 85;
                endcase
                len = $urandom_range(10, 120);
                repeat (len) begin
                    i_stall <= ($urandom_range(0, 99) < density);
                    @(posedge i_clk);
                end
            end
            segment++;
        end
    end

    // ---------------------------------------------------------------------
    // Sender and configuration tasks. All of them are entered right after a
    // rising edge and drive with nonblocking assignments.
    // ---------------------------------------------------------------------

    // Offers one particle and holds it until the block takes the beat.
    task automatic send_particle(input t_particle p, input t_update expected);
        i_valid         <= 1'b1;
        i_frame_time    <= p.ft;
        i_particle_kind <= p.kind;
        i_pos_x         <= p.px;
        i_pos_y         <= p.py;
        i_pos_z         <= p.pz;
        i_vel_x         <= p.vx;
        i_vel_y         <= p.vy;
        i_vel_z         <= p.vz;
        i_ramp_in       <= p.ramp;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_updates.push_back(expected);
    endtask

    // Bursts of back-to-back beats separated by random gaps; now and then a
    // long burst with no gaps at all.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(0, 20);
        end
    endtask

    task automatic read_gravity();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= GRAVITY_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        check_field("gravity readback", {20'b0, gravity_setting}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes the gravity register once the pipeline is empty, then reads it
    // back. Only the low 12 bits of the write data land in the register.
    task automatic write_gravity(input logic [31:0] value);
        while (pending_updates.size() != 0) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= GRAVITY_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        gravity_setting = value[11:0];
        read_gravity();
    endtask

    task automatic add_row(input t_particle p, input logic typed, input t_update r);
        t_row row;
        row.p = p;
        row.typed = typed;
        row.r = r;
        directed_rows.push_back(row);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return 32'($urandom_range(0, 4095)) - 32'd2048;
            2:       return ($urandom_range(0, 1) ? 32'h7fff_f000 : 32'h8000_0000)
                            + 32'($urandom_range(0, 4095));
            default: return 32'($signed($urandom) >>> $urandom_range(4, 24));
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        logic [31:0] gravity_plan [6];
        t_particle   p;
        int          drain;

        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        i_valid         <= 1'b0;
        i_frame_time    <= '0;
        i_particle_kind <= '0;
        i_pos_x         <= '0;
        i_pos_y         <= '0;
        i_pos_z         <= '0;
        i_vel_x         <= '0;
        i_vel_y         <= '0;
        i_vel_z         <= '0;
        i_ramp_in       <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Gravity must come out of reset at its default.
        read_gravity();

        // Directed rows. Where the frame time is zero nothing moves, so the expected
        // particle can be written down directly; those rows pin the color tables
        // and the table ends, and one static row at the field extremes pins saturation.
        add_row('{16'h0000, KIND_STATIC, 32'sd100, -32'sd100, 32'h1234_5678,
                  32'sd1, -32'sd1, 32'h7fff_ffff, 16'h1234}, 1'b1,
                '{32'sd100, -32'sd100, 32'h1234_5678, 32'sd1, -32'sd1, 32'h7fff_ffff,
                  16'h1234, 8'h00, 1'b0, 1'b0});
        add_row('{16'hffff, KIND_STATIC, 32'h7fff_ffff, 32'h8000_0000, 32'h0,
                  32'h7fff_ffff, 32'h8000_0000, 32'h0, 16'hffff}, 1'b1,
                '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0,
                  16'hffff, 8'h00, 1'b0, 1'b0});
        add_row('{16'h0000, KIND_FIRE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0000},
                1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0000, 8'h6d, 1'b1, 1'b0});
        add_row('{16'h0000, KIND_FIRE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h5fff},
                1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h5fff, 8'h03, 1'b1, 1'b0});
        add_row('{16'h0000, KIND_FIRE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h6000},
                1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h6000, 8'h00, 1'b0, 1'b1});
        add_row('{16'h0000, KIND_EXPLODE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h7fff},
                1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h7fff, 8'h61, 1'b1, 1'b0});
        add_row('{16'h0000, KIND_EXPLODE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h8000},
                1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h8000, 8'h00, 1'b0, 1'b1});
        add_row('{16'h0000, KIND_EXPLODE2, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h7000},
                1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h7000, 8'h66, 1'b1, 1'b0});
        add_row('{16'h0000, KIND_EXPLODE2, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'hffff},
                1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'hffff, 8'h00, 1'b0, 1'b1});

        // Rows below go through the predictor.
        add_row('{16'hffff, KIND_FIRE, 32'h0, 32'h0, 32'h7fff_ff00, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 16'hffff}, 1'b0, '0);
        add_row('{16'h0444, KIND_FIRE, 32'sd5000, -32'sd5000, 32'sd0, 32'sd2560,
                  -32'sd2560, 32'sd0, 16'h0000}, 1'b0, '0);
        add_row('{16'hffff, KIND_EXPLODE, 32'h0, 32'h0, 32'h0, 32'h7fff_ffff,
                  32'h8000_0000, 32'h0100_0000, 16'h0000}, 1'b0, '0);
        add_row('{16'h0001, KIND_EXPLODE, 32'h0, 32'h0, 32'h0, -32'sd1, -32'sd3,
                  32'sd1, 16'h0fff}, 1'b0, '0);
        add_row('{16'hffff, KIND_EXPLODE2, 32'h8000_0000, 32'h7fff_ffff, 32'h0,
                  32'h8000_0000, 32'h7fff_ffff, -32'sd7, 16'h1000}, 1'b0, '0);
        add_row('{16'h4000, KIND_BLOB, 32'sd1000, 32'sd2000, 32'sd3000, -32'sd12345,
                  32'sd6789, 32'h0fff_ffff, 16'habcd}, 1'b0, '0);
        add_row('{16'hffff, KIND_BLOB2, 32'h7fff_ffff, 32'h8000_0000, 32'h0,
                  32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'h5555}, 1'b0, '0);
        add_row('{16'h0444, KIND_GRAV, 32'h0, 32'h0, 32'sd25600, 32'h0, 32'h0,
                  32'h0, 16'h0000}, 1'b0, '0);
        add_row('{16'hffff, KIND_SLOWGRAV, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0,
                  32'h8000_0000, 16'hffff}, 1'b0, '0);
        add_row('{16'hffff, KIND_STATIC, 32'h8000_0000, 32'h0, 32'h0, -32'sd1,
                  32'h0, 32'h0, 16'h0000}, 1'b0, '0);
        add_row('{16'h8000, KIND_BLOB2, 32'h0, 32'h0, 32'h0, -32'sd256, 32'sd256,
                  -32'sd1, 16'h0000}, 1'b0, '0);

        foreach (directed_rows[i]) begin
            send_particle(directed_rows[i].p,
                          directed_rows[i].typed ? directed_rows[i].r
                                                 : update_particle(directed_rows[i].p));
            pace_sender();
        end
        i_valid <= 1'b0;

        // Random phases, each under its own gravity setting. Zero selects the
        // default, and the fourth value sets every upper data bit that the
        // register drops.
        gravity_plan = '{32'h0000_0000, 32'h0000_0fff, 32'h0000_0001, 32'hffff_f000,
                         $urandom, $urandom};
        foreach (gravity_plan[ph]) begin
            write_gravity(gravity_plan[ph]);
            repeat (RANDOM_PER_PHASE) begin
                p.kind = t_kind'($urandom_range(0, 7));
                case ($urandom_range(0, 3))
                    0:       p.ft = 16'($urandom);
                    1:       p.ft = 16'($urandom_range(0, 2200));
                    2:       p.ft = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
                    default: p.ft = 16'($urandom_range(0, 65535));
                endcase
                p.px = pick_coord();
                p.py = pick_coord();
                p.pz = pick_coord();
                p.vx = pick_coord();
                p.vy = pick_coord();
                p.vz = pick_coord();
                // Half of the ramps sit inside or just past the color tables.
                case ($urandom_range(0, 3))
                    0:       p.ramp = 16'($urandom);
                    3:       p.ramp = 16'hffff - 16'($urandom_range(0, 3));
                    default: p.ramp = {4'($urandom_range(0, 8)), 12'($urandom)};
                endcase
                send_particle(p, update_particle(p));
                pace_sender();
            end
            i_valid <= 1'b0;
        end

        // Drain, then give the pipeline time to show any extra beat.
        drain = 0;
        while (pending_updates.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_updates.size() != 0) begin
            $error("%0d expected particles never came out", pending_updates.size());
            mismatch_count++;
        end

        if (mismatch_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
